// File: hw/rtl/neuron_backprop_momentum_update_defines.svh
// Assertion macros for the neuron backprop momentum update block.
// Depends on nothing; the asserting module supplies clk and rst_n.
`ifndef NEURON_BACKPROP_MOMENTUM_UPDATE_DEFINES_SVH
`define NEURON_BACKPROP_MOMENTUM_UPDATE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and held off during reset.
`define NBPM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nbpm assertion failed");
// Next-cycle implication, sampled on clk and held off during reset.
`define NBPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nbpm assertion failed");
`else
`define NBPM_ASSERT_IMPL(lbl, ante, cons)
`define NBPM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/nbpm_pkg.sv
// Package for the neuron backprop momentum update block: widths, types,
// operation and register codes, and the rounding and saturation helpers.
// Depends on nothing.
`default_nettype none

package nbpm_pkg;

  // Table geometry and number format.
  localparam int ConnCount    = 64;
  localparam int IdxBits      = $clog2(ConnCount);
  localparam int ValBits      = 24;
  localparam int FracBits     = 16;
  localparam int AccBits      = 2 * ValBits;
  localparam int WideBits     = AccBits + 2;
  localparam int CoefBits     = 17;
  localparam int CoefShift    = 16;
  localparam int CoefProdBits = ValBits + CoefBits + 1;
  localparam int CfgIdxBits   = 2;
  localparam int CfgDataBits  = CoefBits;

  typedef logic signed [ValBits-1:0]      val_t;
  typedef logic signed [AccBits-1:0]      acc_t;
  typedef logic signed [WideBits-1:0]     wide_t;
  typedef logic signed [CoefProdBits-1:0] cprod_t;
  typedef logic        [CoefBits-1:0]     coef_t;
  typedef logic        [IdxBits-1:0]      idx_t;

  // Coefficient 1.0 and 0.5 in Q1.16, and 1.0 in the value format.
  localparam coef_t CoefOne  = coef_t'(1) << CoefShift;
  localparam coef_t CoefHalf = CoefOne >> 1;
  localparam wide_t FracOne  = wide_t'(1) <<< FracBits;

  // Saturation limits.
  localparam wide_t ValMax = (wide_t'(1) <<< (ValBits - 1)) - wide_t'(1);
  localparam wide_t ValMin = -ValMax - wide_t'(1);
  localparam wide_t AccMax = (wide_t'(1) <<< (AccBits - 1)) - wide_t'(1);
  localparam wide_t AccMin = -AccMax - wide_t'(1);

  typedef enum logic [1:0] {
    OP_CONN    = 2'd0,
    OP_OUTGRAD = 2'd1,
    OP_LOAD    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_LEARNING_RATE = 2'd0,
    CFG_MOMENTUM      = 2'd1,
    CFG_BIAS_MODE     = 2'd2
  } cfg_idx_t;

  // A saturated value together with its clip flag.
  typedef struct packed {
    logic clip;
    val_t value;
  } sat_t;

  typedef struct packed {
    logic clip;
    acc_t value;
  } acc_sat_t;

  // Write request from the datapath to the weight and delta tables.
  typedef struct packed {
    logic en;
    idx_t idx;
    val_t weight;
    val_t delta;
  } tbl_wr_t;

  // Arithmetic right shift that rounds half up (add half, then floor).
  function automatic wide_t shr_round(input wide_t x, input int unsigned sh);
    wide_t half;
    half = wide_t'(1) <<< (sh - 1);
    return (x + half) >>> sh;
  endfunction

  // Clip to the value range.
  function automatic sat_t sat_val(input wide_t x);
    sat_t r;
    if (x > ValMax) begin
      r.clip  = 1'b1;
      r.value = val_t'(ValMax);
    end else if (x < ValMin) begin
      r.clip  = 1'b1;
      r.value = val_t'(ValMin);
    end else begin
      r.clip  = 1'b0;
      r.value = val_t'(x);
    end
    return r;
  endfunction

  // Clip to the accumulator range.
  function automatic acc_sat_t sat_acc(input wide_t x);
    acc_sat_t r;
    if (x > AccMax) begin
      r.clip  = 1'b1;
      r.value = acc_t'(AccMax);
    end else if (x < AccMin) begin
      r.clip  = 1'b1;
      r.value = acc_t'(AccMin);
    end else begin
      r.clip  = 1'b0;
      r.value = acc_t'(x);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/neuron_backprop_momentum_update.sv
// Sequencing: an accepted input transaction passes through the four multiply, round and
// saturate stages ST_MUL1 to ST_MUL4 and then ST_DONE, where the result is registered and
// out_valid rises. One transaction at a time: in_stall is high outside ST_IDLE, and
// out_stall on a waiting result holds the item in ST_DONE.
// Reset: clears the accumulator and the delta valid bits, sets rate and
// momentum to 0.5 and bias mode off; weights are undefined until loaded.
`default_nettype none
`include "neuron_backprop_momentum_update_defines.svh"

module neuron_backprop_momentum_update
  import nbpm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Configuration write port.
  input  wire logic                   cfg_we,
  input  wire logic [CfgIdxBits-1:0]  cfg_index,
  input  wire logic [CfgDataBits-1:0] cfg_data,
  // Input channel.
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             in_operation,
  input  wire logic [IdxBits-1:0]     in_conn_index,
  input  wire logic [ValBits-1:0]     in_value,
  input  wire logic [ValBits-1:0]     in_neuron_output,
  input  wire logic                   in_last,
  // Result channel.
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [ValBits-1:0]          out_new_weight,
  output logic [ValBits-1:0]          out_neuron_gradient,
  output logic                        out_gradient_valid,
  output logic                        out_saturated
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL1 = 6'b000010,
    ST_MUL2 = 6'b000100,
    ST_MUL3 = 6'b001000,
    ST_MUL4 = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  localparam logic [IdxBits:0] ConnLimit = (IdxBits + 1)'(ConnCount);

  state_t state_r, state_nxt;
  logic   accept;
  logic   advance;

  // Configuration registers.
  coef_t lr_r;
  coef_t mom_r;
  logic  bias_r;
  coef_t cfg_coef;

  // Held item.
  op_t  op_r;
  idx_t idx_r;
  val_t val_r;
  val_t o_r;
  logic last_r;
  logic idx_ok;

  // Table interface.
  tbl_wr_t tbl_wr;
  val_t    tbl_weight;
  val_t    tbl_delta;
  val_t    w_eff;
  val_t    od_eff;

  // Accumulator.
  acc_t acc_r;

  // Stage registers.
  acc_t   p_r, vo_r, oo_r;
  val_t   go_r, d_r, e_r, s_r, nd_r;
  logic   go_clip_r, d_clip_r, e_clip_r, s_clip_r, nd_clip_r, acc_clip_r;
  acc_t   acc_new_r;
  cprod_t t_lr_r, t_mom_r;
  acc_t   gp_r;

  // Stage results.
  sat_t     go_s, d_s, e_s, s_s, nd_s, nw_s, grad_s;
  acc_sat_t acc_s;
  val_t     gsel;

  // Result register.
  logic out_valid_r;
  val_t out_new_weight_r;
  val_t out_neuron_gradient_r;
  logic out_gradient_valid_r;
  logic out_saturated_r;
  val_t res_weight;
  val_t res_grad;
  logic res_gvalid;
  logic res_clip;
  logic grad_used;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign advance  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Sequencer: one item at a time through the multiply stages.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_MUL1;
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_MUL3;
      ST_MUL3: state_nxt = ST_MUL4;
      ST_MUL4: state_nxt = ST_DONE;
      ST_DONE: begin
        if (advance) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration writes; coefficients above one are held at one.
  assign cfg_coef = (cfg_data > CoefOne) ? CoefOne : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r   <= CoefHalf;
      mom_r  <= CoefHalf;
      bias_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LEARNING_RATE: lr_r   <= cfg_coef;
        CFG_MOMENTUM:      mom_r  <= cfg_coef;
        CFG_BIAS_MODE:     bias_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Capture the input transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= op_t'(in_operation);
      idx_r  <= in_conn_index;
      val_r  <= val_t'(in_value);
      o_r    <= val_t'(in_neuron_output);
      last_r <= in_last;
    end
  end

  assign idx_ok = ({1'b0, idx_r} < ConnLimit);

  nbpm_tables u_tables (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .rd_idx    (in_conn_index),
    .wr        (tbl_wr),
    .rd_weight (tbl_weight),
    .rd_delta  (tbl_delta)
  );

  // Connections outside the table use weight and delta zero.
  assign w_eff  = idx_ok ? tbl_weight : '0;
  assign od_eff = idx_ok ? tbl_delta : '0;

  // The stage registers recompute every cycle from the held item and table
  // data, so each one has settled by the time the item reaches ST_DONE.

  // Stage 1: the three wide products.
  always_ff @(posedge clk) begin
    p_r  <= acc_t'(w_eff) * acc_t'(val_r);
    vo_r <= acc_t'(val_r) * acc_t'(o_r);
    oo_r <= acc_t'(o_r) * acc_t'(o_r);
  end

  // Stage 2: round and clip the products, accumulate, output error.
  assign go_s  = sat_val(shr_round(wide_t'(vo_r), FracBits));
  assign d_s   = sat_val(FracOne - shr_round(wide_t'(oo_r), FracBits));
  assign e_s   = sat_val(wide_t'(val_r) - wide_t'(o_r));
  assign acc_s = sat_acc(wide_t'(acc_r) + wide_t'(p_r));

  always_ff @(posedge clk) begin
    go_r       <= go_s.value;
    go_clip_r  <= go_s.clip;
    d_r        <= d_s.value;
    d_clip_r   <= d_s.clip;
    e_r        <= e_s.value;
    e_clip_r   <= e_s.clip;
    acc_new_r  <= acc_s.value;
    acc_clip_r <= acc_s.clip;
  end

  // Stage 3: rate and momentum products, rescaled sum.
  assign s_s = sat_val(shr_round(wide_t'(acc_new_r), FracBits));

  always_ff @(posedge clk) begin
    t_lr_r   <= cprod_t'(go_r) * cprod_t'($signed({1'b0, lr_r}));
    t_mom_r  <= cprod_t'(od_eff) * cprod_t'($signed({1'b0, mom_r}));
    s_r      <= s_s.value;
    s_clip_r <= s_s.clip;
  end

  // Stage 4: new delta, and the gradient product with the derivative.
  assign nd_s = sat_val(shr_round(wide_t'(t_lr_r) + wide_t'(t_mom_r), CoefShift));
  assign gsel = (op_r == OP_CONN) ? s_r : e_r;

  always_ff @(posedge clk) begin
    nd_r      <= nd_s.value;
    nd_clip_r <= nd_s.clip;
    gp_r      <= acc_t'(gsel) * acc_t'(d_r);
  end

  // Final step: new weight, gradient and the result fields by operation.
  assign nw_s      = sat_val(wide_t'(w_eff) + wide_t'(nd_r));
  assign grad_s    = sat_val(shr_round(wide_t'(gp_r), FracBits));
  assign grad_used = last_r && !bias_r;

  always_comb begin
    res_weight = '0;
    res_grad   = '0;
    res_gvalid = 1'b0;
    res_clip   = 1'b0;
    unique case (op_r)
      OP_CONN: begin
        res_weight = idx_ok ? nw_s.value : '0;
        res_grad   = grad_used ? grad_s.value : '0;
        res_gvalid = last_r;
        res_clip   = go_clip_r || acc_clip_r || nd_clip_r || (idx_ok && nw_s.clip) ||
                     (grad_used && (s_clip_r || d_clip_r || grad_s.clip));
      end
      OP_OUTGRAD: begin
        res_grad   = grad_s.value;
        res_gvalid = 1'b1;
        res_clip   = e_clip_r || d_clip_r || grad_s.clip;
      end
      OP_LOAD: begin
        res_weight = idx_ok ? val_r : '0;
      end
      OP_NONE: ;
      default: ;
    endcase
  end

  // Table write-back as the item leaves.
  always_comb begin
    tbl_wr.en     = advance && idx_ok && ((op_r == OP_CONN) || (op_r == OP_LOAD));
    tbl_wr.idx    = idx_r;
    tbl_wr.weight = (op_r == OP_CONN) ? nw_s.value : val_r;
    tbl_wr.delta  = (op_r == OP_CONN) ? nd_r : '0;
  end

  // Gradient accumulator: cleared after the last connection step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (advance && (op_r == OP_CONN)) begin
      acc_r <= last_r ? '0 : acc_new_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_new_weight_r      <= res_weight;
      out_neuron_gradient_r <= res_grad;
      out_gradient_valid_r  <= res_gvalid;
      out_saturated_r       <= res_clip;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_new_weight      = out_new_weight_r;
  assign out_neuron_gradient = out_neuron_gradient_r;
  assign out_gradient_valid  = out_gradient_valid_r;
  assign out_saturated       = out_saturated_r;

  // Checks on sequencing, result hand-off and accumulator clearing.
  `NBPM_ASSERT_NEXT(a_accept_starts, accept, state_r == ST_MUL1)
  `NBPM_ASSERT_NEXT(a_done_waits, state_r == ST_DONE && out_valid_r && out_stall, state_r == ST_DONE && out_valid_r)
  `NBPM_ASSERT_NEXT(a_acc_clears, advance && op_r == OP_CONN && last_r, acc_r == '0)
  `NBPM_ASSERT_IMPL(a_grad_zero, out_valid_r && !out_gradient_valid_r, out_neuron_gradient_r == '0)

endmodule

`default_nettype wire

// File: hw/rtl/nbpm_tables.sv
// Weight and delta tables of the backprop unit: two synchronous memories
// with registered read data, plus per-entry valid bits for the delta table.
// Depends on nbpm_pkg.
`default_nettype none

module nbpm_tables
  import nbpm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    rd_en,
  input  wire idx_t    rd_idx,
  input  wire tbl_wr_t wr,
  output val_t         rd_weight,
  output val_t         rd_delta
);

  val_t weight_mem [ConnCount];
  val_t delta_mem  [ConnCount];

  logic [ConnCount-1:0] delta_ok_r;
  val_t                 weight_rd_r;
  val_t                 delta_rd_r;
  logic                 delta_ok_rd_r;

  // Memory write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      weight_mem[wr.idx] <= wr.weight;
      delta_mem[wr.idx]  <= wr.delta;
    end
    if (rd_en) begin
      weight_rd_r   <= weight_mem[rd_idx];
      delta_rd_r    <= delta_mem[rd_idx];
      delta_ok_rd_r <= delta_ok_r[rd_idx];
    end
  end

  // A delta entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_ok_r <= '0;
    end else if (wr.en) begin
      delta_ok_r[wr.idx] <= 1'b1;
    end
  end

  assign rd_weight = weight_rd_r;
  assign rd_delta  = delta_ok_rd_r ? delta_rd_r : '0;

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for neuron_backprop_momentum_update: directed table, then random
// backprop passes under several rate, momentum and bias settings, checked by a predictor.
// Depends on nbpm_pkg and the neuron_backprop_momentum_update RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nbpm_pkg::*;

  localparam int ClkPeriod   = 10;
  localparam int IdlePercent = 15;
  localparam int PhaseItems  = 80;
  localparam int HoldAt      = 150;
  localparam int HoldCycles  = 80;
  localparam int DrainCycles = 20;
  localparam int CycleLimit  = 100000;
  localparam int FracUnit    = 1 << FracBits;
  localparam int CoefTop     = (1 << CoefBits) - 1;

  localparam longint ValHi    = (longint'(1) <<< (ValBits - 1)) - 1;
  localparam longint ValLo    = -ValHi - 1;
  localparam longint AccHi    = (longint'(1) <<< (AccBits - 1)) - 1;
  localparam longint AccLo    = -AccHi - 1;
  localparam longint CoefUnit = longint'(CoefOne);

  localparam val_t VMax    = val_t'(ValMax);
  localparam val_t VMin    = val_t'(ValMin);
  localparam val_t Zero    = val_t'(0);
  localparam val_t AllOnes = val_t'(-1);
  localparam val_t One     = val_t'(FracUnit);
  localparam val_t Half    = val_t'(FracUnit / 2);
  localparam val_t NegHalf = val_t'(-(FracUnit / 2));
  localparam val_t Quarter = val_t'(FracUnit / 4);
  localparam val_t NegTwo  = val_t'(-2 * FracUnit);

  // One result transaction.
  typedef struct packed {
    val_t weight;
    val_t grad;
    logic gvalid;
    logic sat;
  } res_t;

  // One row of the directed table; want is used only where known is set.
  typedef struct packed {
    op_t  op;
    idx_t idx;
    val_t val;
    val_t outp;
    logic last;
    logic known;
    res_t want;
  } vec_t;

  localparam res_t NoResult = '0;

  localparam int NumDirected = 23;
  localparam vec_t DirTable [NumDirected] = '{
    // Operation three changes nothing and returns zeros.
    '{OP_NONE,    6'd0,  Zero,    Zero,    1'b0, 1'b1, NoResult},
    '{OP_NONE,    6'd63, AllOnes, AllOnes, 1'b1, 1'b1, NoResult},
    // Loads echo the weight; a last mark on a load has no effect.
    '{OP_LOAD,    6'd0,  VMax,    Zero,    1'b0, 1'b1, '{VMax, Zero, 1'b0, 1'b0}},
    '{OP_LOAD,    6'd63, VMin,    Zero,    1'b0, 1'b1, '{VMin, Zero, 1'b0, 1'b0}},
    '{OP_LOAD,    6'd21, One,     Zero,    1'b1, 1'b1, '{One, Zero, 1'b0, 1'b0}},
    '{OP_LOAD,    6'd42, NegHalf, Zero,    1'b0, 1'b1, '{NegHalf, Zero, 1'b0, 1'b0}},
    // Output gradient: derivative of one at zero output, clips on error, derivative and gradient, zero error.
    '{OP_OUTGRAD, 6'd5,  VMax,    Zero,    1'b0, 1'b1, '{Zero, VMax, 1'b1, 1'b0}},
    '{OP_OUTGRAD, 6'd5,  VMin,    VMax,    1'b0, 1'b1, '{Zero, VMax, 1'b1, 1'b1}},
    '{OP_OUTGRAD, 6'd5,  Half,    Half,    1'b0, 1'b1, '{Zero, Zero, 1'b1, 1'b0}},
    '{OP_OUTGRAD, 6'd9,  One,     NegHalf, 1'b0, 1'b0, NoResult},
    // A short pass at reset rate and momentum, with weight saturation.
    '{OP_CONN,    6'd21, One,     Half,    1'b0, 1'b0, NoResult},
    '{OP_CONN,    6'd42, NegTwo,  Quarter, 1'b0, 1'b0, NoResult},
    '{OP_CONN,    6'd0,  VMax,    VMax,    1'b0, 1'b0, NoResult},
    '{OP_CONN,    6'd63, VMax,    VMin,    1'b1, 1'b0, NoResult},
    '{OP_CONN,    6'd21, Zero,    Zero,    1'b1, 1'b0, NoResult},
    // Accumulator clips high.
    '{OP_LOAD,    6'd63, VMin,    Zero,    1'b0, 1'b1, '{VMin, Zero, 1'b0, 1'b0}},
    '{OP_CONN,    6'd63, VMin,    Zero,    1'b0, 1'b0, NoResult},
    '{OP_CONN,    6'd63, VMin,    Zero,    1'b1, 1'b0, NoResult},
    // Accumulator clips low.
    '{OP_LOAD,    6'd0,  VMin,    Zero,    1'b0, 1'b1, '{VMin, Zero, 1'b0, 1'b0}},
    '{OP_CONN,    6'd0,  VMax,    Zero,    1'b0, 1'b0, NoResult},
    '{OP_CONN,    6'd0,  VMax,    Zero,    1'b0, 1'b0, NoResult},
    '{OP_CONN,    6'd0,  VMax,    Zero,    1'b1, 1'b0, NoResult},
    '{OP_OUTGRAD, 6'd0,  VMax,    VMin,    1'b0, 1'b0, NoResult}
  };

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CfgIdxBits-1:0]  cfg_index;
  logic [CfgDataBits-1:0] cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [1:0]             in_operation;
  logic [IdxBits-1:0]     in_conn_index;
  logic [ValBits-1:0]     in_value;
  logic [ValBits-1:0]     in_neuron_output;
  logic                   in_last;
  logic                   out_valid;
  logic                   out_stall;
  logic [ValBits-1:0]     out_new_weight;
  logic [ValBits-1:0]     out_neuron_gradient;
  logic                   out_gradient_valid;
  logic                   out_saturated;

  // Predictor state and configuration.
  longint      weight_mem [ConnCount];
  longint      delta_mem  [ConnCount];
  longint      grad_sum;
  int unsigned rate_q;
  int unsigned mom_q;
  bit          bias_on;
  bit          clip_hit;

  res_t        pending_results [$];
  idx_t        loaded_list [$];
  bit          loaded_flag [ConnCount];
  bit          no_gaps = 1'b0;
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned grads_seen = 0;
  int unsigned sats_seen = 0;
  int unsigned settings_run = 0;
  int unsigned cycle_count = 0;

  neuron_backprop_momentum_update i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_conn_index       (in_conn_index),
    .in_value            (in_value),
    .in_neuron_output    (in_neuron_output),
    .in_last             (in_last),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_new_weight      (out_new_weight),
    .out_neuron_gradient (out_neuron_gradient),
    .out_gradient_valid  (out_gradient_valid),
    .out_saturated       (out_saturated)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // Clip to the Q8.16 range and note the clip.
  function automatic longint limit_val(longint v);
    if (v > ValHi) begin
      clip_hit = 1'b1;
      return ValHi;
    end
    if (v < ValLo) begin
      clip_hit = 1'b1;
      return ValLo;
    end
    return v;
  endfunction

  // Right shift rounding half up.
  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // tanh derivative 1 - o*o.
  function automatic longint slope(longint o);
    return limit_val(longint'(FracUnit) - round_shift(o * o, FracBits));
  endfunction

  // Coefficients above one act as one.
  function automatic longint coef_eff(int unsigned c);
    return (longint'(c) > CoefUnit) ? CoefUnit : longint'(c);
  endfunction

  // Expected result of one transaction; updates the predictor tables and sum.
  // The index is six bits wide, so it always falls inside the table.
  function automatic res_t backprop_step(op_t op, idx_t idx, val_t v, val_t o, logic last);
    res_t   r;
    longint vv, oo, w, od, p, go, nd, s;
    r = '0;
    clip_hit = 1'b0;
    vv = v;
    oo = o;
    case (op)
      OP_CONN: begin
        w  = weight_mem[idx];
        od = delta_mem[idx];
        p  = w * vv;
        if (p > 0 && grad_sum > AccHi - p) begin
          grad_sum = AccHi;
          clip_hit = 1'b1;
        end else if (p < 0 && grad_sum < AccLo - p) begin
          grad_sum = AccLo;
          clip_hit = 1'b1;
        end else begin
          grad_sum = grad_sum + p;
        end
        go = limit_val(round_shift(vv * oo, FracBits));
        nd = limit_val(round_shift(go * coef_eff(rate_q) + od * coef_eff(mom_q), CoefShift));
        w  = limit_val(w + nd);
        weight_mem[idx] = w;
        delta_mem[idx]  = nd;
        r.weight = val_t'(w);
        if (last) begin
          r.gvalid = 1'b1;
          if (!bias_on) begin
            s = limit_val(round_shift(grad_sum, FracBits));
            r.grad = val_t'(limit_val(round_shift(s * slope(oo), FracBits)));
          end
          grad_sum = 0;
        end
      end
      OP_OUTGRAD: begin
        s = limit_val(vv - oo);
        r.grad   = val_t'(limit_val(round_shift(s * slope(oo), FracBits)));
        r.gvalid = 1'b1;
      end
      OP_LOAD: begin
        weight_mem[idx] = vv;
        delta_mem[idx]  = 0;
        r.weight = v;
      end
      default: begin
      end
    endcase
    r.sat = clip_hit;
    return r;
  endfunction

  // Mostly small values, with extremes and full-range noise mixed in.
  function automatic val_t rand_val(bit narrow);
    int span;
    span = narrow ? FracUnit : 4 * FracUnit;
    case ($urandom_range(15))
      0: return VMax;
      1: return VMin;
      2: return Zero;
      3, 4: return val_t'($urandom);
      default: return val_t'(int'($urandom_range(2 * span)) - span);
    endcase
  endfunction

  // Only indices that hold a loaded weight may be read by a connection step.
  function automatic idx_t pick_loaded();
    return loaded_list[$urandom_range(loaded_list.size() - 1)];
  endfunction

  // Report one mismatch.
  task automatic flag_mismatch(string what, longint got, longint want);
    errors++;
    // Keep the log short if the block is badly broken.
    if (errors <= 100)
      $display("ERROR result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
  endtask

  // Offer one input transaction and record its expected result once accepted.
  task automatic send_item(op_t op, idx_t idx, val_t v, val_t o, logic last, bit known,
                           res_t typed);
    res_t r;
    while (!no_gaps && $urandom_range(99) < IdlePercent) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_conn_index    <= idx;
    in_value         <= v;
    in_neuron_output <= o;
    in_last          <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = backprop_step(op, idx, v, o, last);
    pending_results.push_back(known ? typed : r);
    items_sent++;
    if (op == OP_LOAD && !loaded_flag[idx]) begin
      loaded_flag[idx] = 1'b1;
      loaded_list.push_back(idx);
    end
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write all three registers, back to back.
  task automatic set_coefs(int unsigned lr, int unsigned mom, bit bias);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LEARNING_RATE;
    cfg_data  <= coef_t'(lr);
    @(posedge clk);
    cfg_index <= CFG_MOMENTUM;
    cfg_data  <= coef_t'(mom);
    @(posedge clk);
    cfg_index <= CFG_BIAS_MODE;
    cfg_data  <= coef_t'(bias);
    @(posedge clk);
    cfg_we <= 1'b0;
    rate_q  = lr;
    mom_q   = mom;
    bias_on = bias;
  endtask

  // Random traffic: mostly backprop passes over loaded connections, plus loads,
  // output gradients, passes that never see their last mark, and idle codes.
  task automatic run_phase(int unsigned budget);
    int unsigned done, pick, steps, k;
    bit          drop_last;
    done = 0;
    while (done < budget) begin
      pick = $urandom_range(99);
      if (loaded_list.size() == 0 || pick < 20) begin
        send_item(OP_LOAD, idx_t'($urandom_range(ConnCount - 1)), rand_val(1'b0),
                  rand_val(1'b1), 1'($urandom_range(1)), 1'b0, NoResult);
        done++;
      end else if (pick < 32) begin
        send_item(OP_OUTGRAD, idx_t'($urandom), rand_val(1'b1), rand_val(1'b1),
                  1'($urandom_range(1)), 1'b0, NoResult);
        done++;
      end else if (pick < 36) begin
        send_item(OP_NONE, idx_t'($urandom), val_t'($urandom), val_t'($urandom),
                  1'($urandom_range(1)), 1'b0, NoResult);
      end else begin
        steps     = $urandom_range(1, 6);
        drop_last = ($urandom_range(9) == 0);
        for (k = 0; k < steps; k++)
          send_item(OP_CONN, pick_loaded(), rand_val(1'b0), rand_val(1'b1),
                    (k == steps - 1) && !drop_last, 1'b0, NoResult);
        done += steps;
      end
    end
  endtask

  // One coefficient setting followed by a block of random traffic.
  task automatic run_setting(int unsigned lr, int unsigned mom, bit bias, bit steady);
    drain();
    set_coefs(lr, mom, bias);
    settings_run++;
    no_gaps = steady;
    run_phase(PhaseItems);
    no_gaps = 1'b0;
  endtask

  // Compare one accepted result with the oldest expectation.
  task automatic check_result();
    res_t want;
    results_seen++;
    if (out_gradient_valid) grads_seen++;
    if (out_saturated) sats_seen++;
    if (pending_results.size() == 0) begin
      flag_mismatch("unexpected transaction, new_weight", $signed(out_new_weight), 0);
    end else begin
      want = pending_results.pop_front();
      if (out_new_weight !== want.weight)
        flag_mismatch("new_weight", $signed(out_new_weight), want.weight);
      if (out_neuron_gradient !== want.grad)
        flag_mismatch("neuron_gradient", $signed(out_neuron_gradient), want.grad);
      if (out_gradient_valid !== want.gvalid)
        flag_mismatch("gradient_valid", out_gradient_valid, want.gvalid);
      if (out_saturated !== want.sat)
        flag_mismatch("saturated", out_saturated, want.sat);
    end
  endtask

  // Result side: random stalls, plus one long hold-off so the block backs up.
  initial begin : result_monitor
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) check_result();
      if (hold_left != 0)
        hold_left--;
      else if (!held && results_seen >= HoldAt) begin
        hold_left = HoldCycles;
        held      = 1'b1;
      end
      out_stall <= (hold_left != 0) || (!no_gaps && $urandom_range(99) < IdlePercent);
    end
  end

  // Watchdog on total run length.
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Reset, directed table, then random traffic under several settings.
  initial begin : stimulus
    int unsigned i;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_LEARNING_RATE;
    cfg_data         <= '0;
    in_valid         <= 1'b0;
    in_operation     <= OP_NONE;
    in_conn_index    <= '0;
    in_value         <= '0;
    in_neuron_output <= '0;
    in_last          <= 1'b0;
    for (i = 0; i < ConnCount; i++) begin
      weight_mem[i]  = 0;
      delta_mem[i]   = 0;
      loaded_flag[i] = 1'b0;
    end
    grad_sum = 0;
    rate_q   = 32768;
    mom_q    = 32768;
    bias_on  = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // The directed table runs on the reset values of the registers.
    for (i = 0; i < NumDirected; i++)
      send_item(DirTable[i].op, DirTable[i].idx, DirTable[i].val, DirTable[i].outp,
                DirTable[i].last, DirTable[i].known, DirTable[i].want);

    run_setting(0, 0, 1'b0, 1'b0);
    run_setting(CoefUnit, CoefUnit, 1'b1, 1'b0);
    run_setting(CoefTop, CoefTop, 1'b0, 1'b0);
    run_setting(16384, 60000, 1'b0, 1'b1);
    run_setting($urandom_range(CoefTop), $urandom_range(CoefTop), 1'b1, 1'b0);
    run_setting($urandom_range(CoefUnit), $urandom_range(CoefUnit), 1'($urandom_range(1)),
                1'b0);

    drain();
    repeat (DrainCycles) @(posedge clk);
    $display("Sent %0d transactions (%0d from the directed table) under %0d register settings.",
             items_sent, NumDirected, settings_run + 1);
    $display("Checked %0d results: %0d carried a gradient, %0d were saturated.",
             results_seen, grads_seen, sats_seen);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// File: neuron_backprop_momentum_update.f
+incdir+hw/rtl
hw/rtl/nbpm_pkg.sv
hw/rtl/nbpm_tables.sv
hw/rtl/neuron_backprop_momentum_update.sv
tb/tb.sv
